/* hdl/slpg_pkg.sv */
// Package for the stepped line point generator.
// Holds the prepared-item and result types used by the other modules; no dependencies.
`default_nettype none

package slpg_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned DistW  = 17;
    localparam int unsigned StepW  = 16;

    localparam logic FuncStart   = 1'b0;
    localparam logic FuncAdvance = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic        [DistW-1:0]  abs_dx;
        logic        [DistW-1:0]  abs_dy;
        logic        [DistW-1:0]  max_dist;
        logic                     x_down;
        logic                     y_down;
        logic        [StepW-1:0]  step_len;
    } t_prep;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic                     plot;
        logic                     done_res;
    } t_res;

endpackage

`default_nettype wire

/* hdl/stepped_line_point_generator_unit.sv */
// Stepped line point generator: top level.
// Items pass from the input register through the core into the result register.
// Throughput: one item per cycle while i_ready is high, set by the single
// line-state update per cycle.
// Reset (synchronous, active low) empties both registers, clears the line state
// and sets the step length to one. Uses slpg_prep, slpg_core, slpg_out, slpg_pkg.
`default_nettype none

module stepped_line_point_generator_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_func,
    input  wire logic signed [15:0] i_start_x,
    input  wire logic signed [15:0] i_start_y,
    input  wire logic signed [15:0] i_end_x,
    input  wire logic signed [15:0] i_end_y,
    input  wire logic signed [15:0] i_step_size,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_point_x,
    output logic signed [15:0]      o_point_y,
    output logic                    o_plot,
    output logic                    o_done_res
);

    logic            advance;
    logic            prep_valid;
    logic            fire;
    slpg_pkg::t_prep prep;
    slpg_pkg::t_res  core_res;
    slpg_pkg::t_res  out_res;

    assign fire = prep_valid && advance;

    slpg_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_step_size (i_step_size),
        .i_advance   (advance),
        .o_valid     (prep_valid),
        .o_prep      (prep)
    );

    slpg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_prep  (prep),
        .o_res   (core_res)
    );

    slpg_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_res     (core_res),
        .i_ready   (i_ready),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_res     (out_res)
    );

    assign o_point_x  = out_res.point_x;
    assign o_point_y  = out_res.point_y;
    assign o_plot     = out_res.plot;
    assign o_done_res = out_res.done_res;

endmodule

`default_nettype wire

/* hdl/slpg_prep.sv */
// Input register of the stepped line point generator.
// Captures one item and precomputes deltas, directions and step length; uses slpg_pkg.
`default_nettype none

module slpg_prep (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_func,
    input  wire logic signed [15:0]    i_start_x,
    input  wire logic signed [15:0]    i_start_y,
    input  wire logic signed [15:0]    i_end_x,
    input  wire logic signed [15:0]    i_end_y,
    input  wire logic signed [15:0]    i_step_size,
    input  wire logic                  i_advance,
    output logic                       o_valid,
    output slpg_pkg::t_prep            o_prep
);

    logic                   r_valid;
    slpg_pkg::t_prep        r_prep;
    slpg_pkg::t_prep        n_prep;
    logic signed [16:0]     dx;
    logic signed [16:0]     dy;
    logic        [16:0]     abs_step;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_prep  = r_prep;

    always_comb begin
        dx = 17'(i_end_x) - 17'(i_start_x);
        dy = 17'(i_end_y) - 17'(i_start_y);
        abs_step = i_step_size[15] ? 17'(-17'(i_step_size)) : 17'(i_step_size);
        n_prep.func     = i_func;
        n_prep.start_x  = i_start_x;
        n_prep.start_y  = i_start_y;
        n_prep.abs_dx   = dx[16] ? 17'(-dx) : 17'(dx);
        n_prep.abs_dy   = dy[16] ? 17'(-dy) : 17'(dy);
        n_prep.max_dist = (n_prep.abs_dx > n_prep.abs_dy) ? n_prep.abs_dx : n_prep.abs_dy;
        n_prep.x_down   = dx[16];
        n_prep.y_down   = dy[16];
        n_prep.step_len = (abs_step == 17'd0) ? 16'd1 : abs_step[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prep <= n_prep;
        end
    end

endmodule

`default_nettype wire

/* hdl/slpg_core.sv */
// Line state and at most one accumulator iteration per item.
// Updates the line state on each transfer from the input register; uses slpg_pkg.
`default_nettype none

module slpg_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  slpg_pkg::t_prep i_prep,
    output slpg_pkg::t_res  o_res
);

    logic signed [15:0] r_cur_x, n_cur_x;
    logic signed [15:0] r_cur_y, n_cur_y;
    logic        [17:0] r_acc_x, n_acc_x;
    logic        [17:0] r_acc_y, n_acc_y;
    logic        [16:0] r_abs_dx, n_abs_dx;
    logic        [16:0] r_abs_dy, n_abs_dy;
    logic        [16:0] r_max_dist, n_max_dist;
    logic               r_x_down, n_x_down;
    logic               r_y_down, n_y_down;
    logic        [17:0] r_iteration, n_iteration;
    logic        [15:0] r_step_len, n_step_len;
    logic        [15:0] r_step_phase, n_step_phase;
    logic               r_active, n_active;

    logic        [17:0] sum_x;
    logic        [17:0] sum_y;
    logic        [17:0] max_ext;
    logic               move_x;
    logic               move_y;
    logic               last;
    logic        [15:0] phase_inc;

    always_comb begin
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_acc_x      = r_acc_x;
        n_acc_y      = r_acc_y;
        n_abs_dx     = r_abs_dx;
        n_abs_dy     = r_abs_dy;
        n_max_dist   = r_max_dist;
        n_x_down     = r_x_down;
        n_y_down     = r_y_down;
        n_iteration  = r_iteration;
        n_step_len   = r_step_len;
        n_step_phase = r_step_phase;
        n_active     = r_active;
        o_res.plot     = 1'b0;
        o_res.done_res = 1'b0;

        max_ext   = {1'b0, r_max_dist};
        sum_x     = r_acc_x + {1'b0, r_abs_dx};
        sum_y     = r_acc_y + {1'b0, r_abs_dy};
        move_x    = sum_x > max_ext;
        move_y    = sum_y > max_ext;
        last      = r_iteration == max_ext;
        phase_inc = r_step_phase + 16'd1;

        if (i_prep.func == slpg_pkg::FuncStart) begin
            n_step_len   = i_prep.step_len;
            n_abs_dx     = i_prep.abs_dx;
            n_abs_dy     = i_prep.abs_dy;
            n_max_dist   = i_prep.max_dist;
            n_x_down     = i_prep.x_down;
            n_y_down     = i_prep.y_down;
            n_cur_x      = i_prep.start_x;
            n_cur_y      = i_prep.start_y;
            n_acc_x      = 18'd0;
            n_acc_y      = 18'd0;
            n_iteration  = 18'd0;
            n_step_phase = 16'd0;
            n_active     = 1'b1;
            o_res.plot   = 1'b1;
        end else if (!r_active || (r_iteration > max_ext)) begin
            n_active       = 1'b0;
            o_res.done_res = 1'b1;
        end else begin
            n_acc_x = move_x ? 18'(sum_x - max_ext) : sum_x;
            n_acc_y = move_y ? 18'(sum_y - max_ext) : sum_y;
            if (move_x) begin
                n_cur_x = r_x_down ? 16'(r_cur_x - 16'sd1) : 16'(r_cur_x + 16'sd1);
            end
            if (move_y) begin
                n_cur_y = r_y_down ? 16'(r_cur_y - 16'sd1) : 16'(r_cur_y + 16'sd1);
            end
            if (move_x || move_y) begin
                o_res.plot   = (r_step_phase == 16'd0) || last;
                n_step_phase = (phase_inc >= r_step_len) ? 16'd0 : phase_inc;
            end
            n_iteration = r_iteration + 18'd1;
            if (last) begin
                o_res.done_res = 1'b1;
                n_active       = 1'b0;
            end
        end

        o_res.point_x = n_cur_x;
        o_res.point_y = n_cur_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_abs_dx     <= '0;
            r_abs_dy     <= '0;
            r_max_dist   <= '0;
            r_x_down     <= 1'b0;
            r_y_down     <= 1'b0;
            r_iteration  <= '0;
            r_step_len   <= 16'd1;
            r_step_phase <= '0;
            r_active     <= 1'b0;
        end else if (i_fire) begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_acc_x      <= n_acc_x;
            r_acc_y      <= n_acc_y;
            r_abs_dx     <= n_abs_dx;
            r_abs_dy     <= n_abs_dy;
            r_max_dist   <= n_max_dist;
            r_x_down     <= n_x_down;
            r_y_down     <= n_y_down;
            r_iteration  <= n_iteration;
            r_step_len   <= n_step_len;
            r_step_phase <= n_step_phase;
            r_active     <= n_active;
        end
    end

endmodule

`default_nettype wire

/* hdl/slpg_out.sv */
// Result register of the stepped line point generator.
// Holds one result until its transfer completes; uses slpg_pkg.
`default_nettype none

module slpg_out (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  slpg_pkg::t_res i_res,
    input  wire logic      i_ready,
    output logic           o_advance,
    output logic           o_valid,
    output slpg_pkg::t_res o_res
);

    logic           r_valid;
    slpg_pkg::t_res r_res;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire
